// File: rtl/assert_macros.svh
// Assertion macros used by the top level to check this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must never be true while out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// Antecedent on one edge forces the consequent on the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lee_pkg.sv
// Shared types and constants of the line editor.
package lee_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int BYTE_W     = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_BS = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SP = 8'd32;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_BS,
        CMD_CR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAR,
        S_BS0,
        S_BS1,
        S_BS2,
        S_HEAD_LF,
        S_HEAD_CR,
        S_BODY,
        S_TAIL_LF,
        S_TAIL_CR
    } back_state_t;

endpackage

// File: rtl/lee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lee_cmd_fifo.sv
// Short command queue between the classifier and the output sequencer.
module lee_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lee_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output lee_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import lee_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/lee_front.sv
// Input classifier: keeps the fill count, writes the line store, queues commands.
module lee_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lee_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                         rx_valid,
    output logic                         rx_stall,
    input  logic                         fifo_full,
    output logic                         cmd_push,
    output lee_pkg::cmd_t                push_cmd,
    output logic                         wr_en,
    output logic [lee_pkg::ADDR_W-1:0]   wr_addr,
    output logic [lee_pkg::BYTE_W-1:0]   wr_data,
    input  logic                         cr_done,
    output logic                         cr_pending
);
    import lee_pkg::*;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pending_reg, pending_next;
    logic             accept;
    logic             line_full;

    // Stall on a full queue, and in a replay so the line store is not overwritten.
    assign rx_stall   = pending_reg || fifo_full;
    assign accept     = rx_valid && !rx_stall;
    assign line_full  = (fill_reg == CNT_W'(LINE_DEPTH));
    assign cr_pending = pending_reg;
    assign wr_addr    = fill_reg[ADDR_W-1:0];
    assign wr_data    = rx_byte;

    always_comb
    begin
        fill_next      = fill_reg;
        pending_next   = pending_reg;
        cmd_push       = 1'b0;
        wr_en          = 1'b0;
        push_cmd.kind  = CMD_CHAR;
        push_cmd.data  = rx_byte;
        push_cmd.count = fill_reg;
        if (cr_done)
        begin
            pending_next = 1'b0;
        end
        if (accept)
        begin
            priority if (rx_byte == CH_BS)
            begin
                cmd_push      = 1'b1;
                push_cmd.kind = CMD_BS;
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            else if (rx_byte == CH_CR)
            begin
                cmd_push      = 1'b1;
                push_cmd.kind = CMD_CR;
                fill_next     = '0;
                pending_next  = 1'b1;
            end
            else if (!line_full)
            begin
                cmd_push  = 1'b1;
                wr_en     = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
            // otherwise drop: full line, no echo
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// File: rtl/lee_back.sv
// Output sequencer: expands each command into echo bytes and replays the line.
module lee_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fifo_empty,
    input  lee_pkg::cmd_t                pop_cmd,
    output logic                         cmd_pop,
    output logic [lee_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [lee_pkg::BYTE_W-1:0]   rd_data,
    output logic                         cr_done,
    output logic [lee_pkg::BYTE_W-1:0]   tx_byte,
    output logic                         last,
    output logic                         tx_valid,
    input  logic                         tx_stall
);
    import lee_pkg::*;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              can_load;
    logic              load;
    logic [BYTE_W-1:0] load_byte;
    logic              load_last;

    assign can_load = !valid_reg || !tx_stall;
    assign tx_byte  = byte_reg;
    assign last     = last_reg;
    assign tx_valid = valid_reg;
    // Address follows the next index so the registered read lines up with the body state.
    assign rd_addr  = idx_next[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        cr_done    = 1'b0;
        load       = 1'b0;
        load_byte  = CH_LF;
        load_last  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = pop_cmd;
                    idx_next = '0;
                    unique case (pop_cmd.kind)
                        CMD_BS:   state_next = S_BS0;
                        CMD_CR:   state_next = S_HEAD_LF;
                        default:  state_next = S_CHAR;
                    endcase
                end
            end
            S_CHAR:
            begin
                load_byte = cmd_reg.data;
                load_last = 1'b1;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BS0:
            begin
                load_byte = CH_BS;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = S_BS1;
                end
            end
            S_BS1:
            begin
                load_byte = CH_SP;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = S_BS2;
                end
            end
            S_BS2:
            begin
                load_byte = CH_BS;
                load_last = 1'b1;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HEAD_LF:
            begin
                load_byte = CH_LF;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = S_HEAD_CR;
                end
            end
            S_HEAD_CR:
            begin
                load_byte = CH_CR;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = (cmd_reg.count == '0) ? S_TAIL_LF : S_BODY;
                end
            end
            S_BODY:
            begin
                load_byte = rd_data;
                if (can_load)
                begin
                    load     = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == cmd_reg.count)
                    begin
                        state_next = S_TAIL_LF;
                    end
                end
            end
            S_TAIL_LF:
            begin
                load_byte = CH_LF;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = S_TAIL_CR;
                end
            end
            S_TAIL_CR:
            begin
                load_byte = CH_CR;
                load_last = 1'b1;
                if (can_load)
                begin
                    load       = 1'b1;
                    cr_done    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        byte_next  = byte_reg;
        last_next  = last_reg;
        valid_next = valid_reg && tx_stall;
        if (load)
        begin
            byte_next  = load_byte;
            last_next  = load_last;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// File: rtl/line_edit_echo_replay.sv
// Top level of the terminal line editor with echo and line replay.
// Received bytes enter on the rx channel and are classified at once: an ordinary byte is
// written to the line store and queued for echo, a backspace queues the erase sequence
// (BS, space, BS) and lowers the fill count, and a carriage return queues a replay of the
// line framed by LF CR on both sides. Ordinary bytes that arrive with the line full are
// dropped without echo. The output sequencer hands out one byte per cycle while tx_stall is
// low, apart from the dispatch step that takes each input from the queue, and marks the final
// byte of each input with last. An ordinary byte expands to one byte, a backspace to three
// and a carriage return with n buffered bytes to 4 + n (36 for a full line of 32). A four-entry
// command queue lets input run ahead of output; after a carriage return the input holds
// stall until the last byte of that replay has been passed to the output register.
`include "assert_macros.svh"

module line_edit_echo_replay (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lee_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       rx_valid,
    output logic                       rx_stall,
    output logic [lee_pkg::BYTE_W-1:0] tx_byte,
    output logic                       last,
    output logic                       tx_valid,
    input  logic                       tx_stall
);
    import lee_pkg::*;

    logic              cmd_push;
    cmd_t              push_cmd;
    logic              cmd_pop;
    cmd_t              pop_cmd;
    logic              fifo_full;
    logic              fifo_empty;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              cr_done;
    logic              cr_pending;
    logic              cr_accept;
    logic              marked_cr;

    lee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .fifo_full  (fifo_full),
        .cmd_push   (cmd_push),
        .push_cmd   (push_cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .cr_done    (cr_done),
        .cr_pending (cr_pending)
    );

    lee_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (cmd_pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    lee_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop_cmd    (pop_cmd),
        .cmd_pop    (cmd_pop),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .cr_done    (cr_done),
        .tx_byte    (tx_byte),
        .last       (last),
        .tx_valid   (tx_valid),
        .tx_stall   (tx_stall)
    );

    assign cr_accept = rx_valid && !rx_stall && (rx_byte == CH_CR);
    assign marked_cr = tx_valid && last && (tx_byte == CH_CR);

    `ASSERT_NEVER(a_no_push_full, cmd_push && fifo_full, "command pushed into full queue")
    `ASSERT_NEVER(a_no_pop_empty, cmd_pop && fifo_empty, "command popped from empty queue")
    `ASSERT_NEVER(a_no_write_replay, wr_en && cr_pending, "line store written during replay")
    `ASSERT_NEXT(a_cr_holds_input, cr_accept, rx_stall, "input not held after carriage return")
    `ASSERT_NEXT(a_replay_end, cr_done, marked_cr, "replay did not end on marked CR")

endmodule
